FILE: rtl/qps_pkg.sv
// qps_pkg: shared types and constants for the quoted parameter splitter
// no dependencies; used by every module of the block

package qps_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [7:0] DEPTH_MAX = 8'd255;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
        logic       header_mode;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] field_index;
        logic [7:0] data;
        logic [5:0] field_length;
        logic [4:0] field_count;
    } result_t;

endpackage

FILE: rtl/qps_in_stage.sv
// qps_in_stage: input register of the splitter, holds one item
// depends on qps_pkg

module qps_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           s_tuser,
    input  logic           take,
    output logic           item_valid,
    output qps_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    qps_pkg::item_t item_reg;
    qps_pkg::item_t item_next;
    logic           load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        item_next.ch          = s_tdata;
        item_next.end_of_text = s_tlast;
        item_next.header_mode = s_tuser;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: rtl/qps_parser.sv
// qps_parser: line state and per-item split decision
// depends on qps_pkg

module qps_parser
#(
    parameter int MAX_FIELDS  = 16,
    parameter int FIELD_BYTES = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  qps_pkg::item_t   item,
    input  logic             free,
    output logic             take,
    output logic             res_valid,
    output qps_pkg::result_t result
);

    localparam int FN_W = $clog2(MAX_FIELDS + 1);
    localparam int CN_W = $clog2(FIELD_BYTES);
    localparam logic [FN_W-1:0] FN_MAX   = FN_W'(MAX_FIELDS);
    localparam logic [CN_W-1:0] CN_LIMIT = CN_W'(FIELD_BYTES - 1);

    logic            line_mode_reg,    line_mode_next;
    logic            line_started_reg, line_started_next;
    logic            in_quote_reg,     in_quote_next;
    logic [7:0]      paren_depth_reg,  paren_depth_next;
    logic [FN_W-1:0] field_number_reg, field_number_next;
    logic [CN_W-1:0] char_number_reg,  char_number_next;
    logic            stopped_reg,      stopped_next;

    logic            fire;
    logic            mode;
    logic            halted;
    logic            is_quote;
    logic            is_comma;
    logic            is_eol;
    logic            can_store;
    logic            do_close;
    logic            do_store;
    logic [FN_W:0]   count;
    logic            has_result;

    assign fire = item_valid && free;
    assign take = free;

    assign mode      = line_started_reg ? line_mode_reg : item.header_mode;
    assign halted    = stopped_reg || (field_number_reg >= FN_MAX);
    assign is_quote  = (item.ch == qps_pkg::CH_QUOTE);
    assign is_comma  = (item.ch == qps_pkg::CH_COMMA);
    assign is_eol    = (item.ch == qps_pkg::CH_CR) || (item.ch == qps_pkg::CH_LF);
    assign can_store = (char_number_reg < CN_LIMIT);

    always_comb
    begin
        count = {1'b0, field_number_reg};
        if ((char_number_reg != '0) && (field_number_reg < FN_MAX))
        begin
            count = count + 1'b1;
        end
    end

    always_comb
    begin
        line_mode_next    = line_mode_reg;
        line_started_next = line_started_reg;
        in_quote_next     = in_quote_reg;
        paren_depth_next  = paren_depth_reg;
        field_number_next = field_number_reg;
        char_number_next  = char_number_reg;
        stopped_next      = stopped_reg;
        do_close          = 1'b0;
        do_store          = 1'b0;
        if (fire)
        begin
            if (!line_started_reg)
            begin
                line_mode_next    = item.header_mode;
                line_started_next = 1'b1;
            end
            if (item.end_of_text)
            begin
                line_mode_next    = 1'b0;
                line_started_next = 1'b0;
                in_quote_next     = 1'b0;
                paren_depth_next  = '0;
                field_number_next = '0;
                char_number_next  = '0;
                stopped_next      = 1'b0;
            end
            else if (!halted)
            begin
                if (!mode)
                begin
                    if (is_eol)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        if (is_quote)
                        begin
                            in_quote_next = !in_quote_reg;
                        end
                        else if (!in_quote_reg)
                        begin
                            if (item.ch == qps_pkg::CH_LPAREN)
                            begin
                                if (paren_depth_reg != qps_pkg::DEPTH_MAX)
                                begin
                                    paren_depth_next = paren_depth_reg + 8'd1;
                                end
                            end
                            else if (item.ch == qps_pkg::CH_RPAREN)
                            begin
                                if (paren_depth_reg != 8'd0)
                                begin
                                    paren_depth_next = paren_depth_reg - 8'd1;
                                end
                            end
                        end
                        if (is_comma && !in_quote_reg && (paren_depth_next == 8'd0))
                        begin
                            do_close = 1'b1;
                        end
                        else
                        begin
                            do_store = can_store;
                        end
                    end
                end
                else
                begin
                    if (is_quote)
                    begin
                        in_quote_next = !in_quote_reg;
                    end
                    else if (is_comma && !in_quote_reg)
                    begin
                        do_close = 1'b1;
                    end
                    else if (is_eol && !in_quote_reg)
                    begin
                        stopped_next = 1'b1;
                    end
                    else
                    begin
                        do_store = can_store;
                    end
                end
                if (do_close)
                begin
                    field_number_next = field_number_reg + 1'b1;
                    char_number_next  = '0;
                    if ((field_number_reg + 1'b1) >= FN_MAX)
                    begin
                        stopped_next = 1'b1;
                    end
                end
                if (do_store)
                begin
                    char_number_next = char_number_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.kind         = qps_pkg::KIND_CHAR;
        result.field_index  = 4'(field_number_reg);
        result.data         = 8'd0;
        result.field_length = 6'd0;
        result.field_count  = 5'd0;
        has_result          = 1'b0;
        if (item.end_of_text)
        begin
            result.kind        = qps_pkg::KIND_DONE;
            result.field_index = 4'd0;
            result.field_count = 5'(count);
            has_result         = 1'b1;
        end
        else if (do_close)
        begin
            result.kind         = qps_pkg::KIND_CLOSE;
            result.field_length = 6'(char_number_reg);
            has_result          = 1'b1;
        end
        else if (do_store)
        begin
            result.data = item.ch;
            has_result  = 1'b1;
        end
    end

    assign res_valid = fire && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg    <= 1'b0;
            line_started_reg <= 1'b0;
            in_quote_reg     <= 1'b0;
            paren_depth_reg  <= '0;
            field_number_reg <= '0;
            char_number_reg  <= '0;
            stopped_reg      <= 1'b0;
        end
        else
        begin
            line_mode_reg    <= line_mode_next;
            line_started_reg <= line_started_next;
            in_quote_reg     <= in_quote_next;
            paren_depth_reg  <= paren_depth_next;
            field_number_reg <= field_number_next;
            char_number_reg  <= char_number_next;
            stopped_reg      <= stopped_next;
        end
    end

    a_field_bound: assert property (@(posedge clk) disable iff (!rst_n)
        field_number_reg <= FN_MAX)
        else $error("field number beyond limit");

    a_char_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_number_reg <= CN_LIMIT)
        else $error("field length beyond capacity");

    a_limit_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (field_number_reg == FN_MAX) |-> stopped_reg)
        else $error("field limit reached without stopping the line");

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.end_of_text) |=>
            (field_number_reg == '0) && (char_number_reg == '0) && !line_started_reg)
        else $error("line state not cleared after line end");

endmodule

FILE: rtl/qps_out_stage.sv
// qps_out_stage: result register toward the master-side stream
// depends on qps_pkg

module qps_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  qps_pkg::result_t result,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,
    output logic [1:0]       m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    qps_pkg::result_t result_reg;

    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && res_valid)
        begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, result_reg.field_count, result_reg.field_length,
                       result_reg.data, result_reg.field_index};
    assign m_tuser  = result_reg.kind;

endmodule

FILE: rtl/quoted_parameter_splitter_top.sv
// quoted_parameter_splitter_top: splits modem response parameter text into fields
// depends on qps_pkg, qps_in_stage, qps_parser, qps_out_stage
//
// usage
//   slave side carries one text byte per item: s_tdata is the byte, s_tlast
//   marks end of text (byte ignored), s_tuser selects header rules and is
//   sampled on the first item of each line
//   master side gives at most one item per input item: a stored field byte,
//   a field closed by a comma with its length, or line done with field count
// timing
//   an item is held in the input register, is decoded combinationally and lands
//   in the result register when the output stage is free; m_tvalid is the
//   registered valid of that result register
//   one item per cycle sustained while m_tready stays high; the state update
//   loop of the parser sets that figure
// reset
//   rst_n clears both stages and the line state; the next item opens a line
// stall
//   while m_tready is low and a result is held, the input register keeps its
//   item and s_tready drops once it is full; no item is lost or repeated

module quoted_parameter_splitter_top
#(
    parameter int MAX_FIELDS  = 16,
    parameter int FIELD_BYTES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,
    input  logic        s_tuser,   // header_mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // field_index, data, field_length, field_count, pad
    output logic [1:0]  m_tuser    // kind
);

    qps_pkg::item_t   item;
    qps_pkg::result_t result;
    logic             item_valid;
    logic             take;
    logic             res_valid;
    logic             free;

    qps_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    qps_parser
    #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FIELD_BYTES (FIELD_BYTES)
    )
    u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .free       (free),
        .take       (take),
        .res_valid  (res_valid),
        .result     (result)
    );

    qps_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .result    (result),
        .free      (free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
